>>> hw/rtl/smcp_pkg.sv
// ----------------------------------------------------------------------------
// smcp_pkg
// Types and constants shared by the serial motor command parser: result codes,
// the ASCII characters that steer parsing, and the table of command words.
// ----------------------------------------------------------------------------
package smcp_pkg;

  typedef logic [2:0] cmd_code_t;
  typedef logic [4:0] letter_t;
  typedef logic [3:0] cmd_len_t;

  localparam cmd_code_t CODE_UNKNOWN  = 3'd0;
  localparam cmd_code_t CODE_ZERO     = 3'd1;
  localparam cmd_code_t CODE_ROTATETO = 3'd2;
  localparam cmd_code_t CODE_CW       = 3'd3;
  localparam cmd_code_t CODE_CCW      = 3'd4;
  localparam cmd_code_t CODE_ROTATE   = 3'd5;
  localparam cmd_code_t CODE_ENA      = 3'd6;
  localparam cmd_code_t CODE_DIS      = 3'd7;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  localparam int NUM_CMDS   = 7;
  localparam int CMD_MAXLEN = 8;

  // Letters are held as their index in the alphabet, A being zero.
  localparam cmd_code_t CMD_CODE [NUM_CMDS] = '{
    CODE_ZERO, CODE_ROTATETO, CODE_CW, CODE_CCW, CODE_ROTATE, CODE_ENA, CODE_DIS
  };

  localparam cmd_len_t CMD_LEN [NUM_CMDS] = '{
    4'd4, 4'd8, 4'd2, 4'd3, 4'd6, 4'd3, 4'd3
  };

  localparam letter_t CMD_TEXT [NUM_CMDS][CMD_MAXLEN] = '{
    '{5'd25, 5'd4,  5'd17, 5'd14, 5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd17, 5'd14, 5'd19, 5'd0,  5'd19, 5'd4,  5'd19, 5'd14},
    '{5'd2,  5'd22, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd2,  5'd2,  5'd22, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd17, 5'd14, 5'd19, 5'd0,  5'd19, 5'd4,  5'd0,  5'd0 },
    '{5'd4,  5'd13, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd3,  5'd8,  5'd18, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0 }
  };

endpackage

>>> hw/rtl/serial_motor_command_parser.sv
// ----------------------------------------------------------------------------
// serial_motor_command_parser
// Parses received characters into motor commands. One character is taken per
// transaction, and a new one can be taken in every clock cycle. Letters are
// case-folded into a command word, digits before the first point build a
// saturating integer, and a newline produces one result transaction in the
// next cycle from the output register, after which the line state is cleared.
// Only a stalled output register holds back the input side. Words longer than
// MAX_WORD_LETTERS letters, empty words and unrecognised words give the
// unknown code; the value and overflow flag are always reported.
// ----------------------------------------------------------------------------
module serial_motor_command_parser #(
  parameter int MAX_WORD_LETTERS = 8,
  parameter int VALUE_BITS       = 20
) (
  input  logic clk,
  input  logic rst,

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_in[7:0]

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // command_code[2:0], argument_value[VALUE_BITS-1:0], value_overflowed, zero fill
  output logic [8*((VALUE_BITS+4+7)/8)-1:0] m_axis_tdata
);

  localparam int OUT_BITS = 8*((VALUE_BITS+4+7)/8);
  localparam int LEN_W    = $clog2(MAX_WORD_LETTERS+2);
  localparam int IDX_W    = $clog2(MAX_WORD_LETTERS);
  localparam int ACC_W    = VALUE_BITS + 4;

  smcp_pkg::letter_t         word_letters [MAX_WORD_LETTERS];
  logic [LEN_W-1:0]          word_length;
  logic [VALUE_BITS-1:0]     integer_accumulator;
  logic                      overflow_seen;
  logic                      after_point;

  logic                      out_valid;
  smcp_pkg::cmd_code_t       out_code;
  logic [VALUE_BITS-1:0]     out_value;
  logic                      out_overflow;

  logic                      accept;
  logic [7:0]                ch;
  logic                      is_digit;
  logic                      is_letter;
  smcp_pkg::letter_t         letter;
  logic [ACC_W-1:0]          acc_sum;
  logic                      acc_over;
  smcp_pkg::cmd_code_t       match_code;
  logic                      same;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;

  assign is_digit  = ch inside {[smcp_pkg::CHAR_DIGIT_0:smcp_pkg::CHAR_DIGIT_9]};
  assign is_letter = ch inside {[smcp_pkg::CHAR_UPPER_A:smcp_pkg::CHAR_UPPER_Z],
                                [smcp_pkg::CHAR_LOWER_A:smcp_pkg::CHAR_LOWER_Z]};
  // Both cases carry the alphabet position plus one in their low five bits.
  assign letter    = smcp_pkg::letter_t'(ch[4:0] - 5'd1);

  assign acc_sum  = (ACC_W'(integer_accumulator) << 3) + (ACC_W'(integer_accumulator) << 1)
                  + ACC_W'(ch[3:0]);
  assign acc_over = |acc_sum[ACC_W-1:VALUE_BITS];

  always_comb begin
    match_code = smcp_pkg::CODE_UNKNOWN;
    same       = 1'b0;
    for (int c = smcp_pkg::NUM_CMDS - 1; c >= 0; c--) begin
      same = (word_length == LEN_W'(smcp_pkg::CMD_LEN[c]));
      for (int i = 0; i < smcp_pkg::CMD_MAXLEN; i++) begin
        if (i < int'(smcp_pkg::CMD_LEN[c]) && word_letters[i] != smcp_pkg::CMD_TEXT[c][i]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        match_code = smcp_pkg::CMD_CODE[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_letter && word_length < LEN_W'(MAX_WORD_LETTERS)) begin
      word_letters[word_length[IDX_W-1:0]] <= letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length         <= '0;
      integer_accumulator <= '0;
      overflow_seen       <= 1'b0;
      after_point         <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (is_digit) begin
          if (!after_point) begin
            if (acc_over) begin
              integer_accumulator <= '1;
              overflow_seen       <= 1'b1;
            end else begin
              integer_accumulator <= acc_sum[VALUE_BITS-1:0];
            end
          end
        end else if (ch == smcp_pkg::CHAR_POINT) begin
          after_point <= 1'b1;
        end else if (is_letter) begin
          if (word_length < LEN_W'(MAX_WORD_LETTERS)) begin
            word_length <= word_length + LEN_W'(1);
          end else begin
            word_length <= LEN_W'(MAX_WORD_LETTERS + 1);
          end
        end else if (ch == smcp_pkg::CHAR_NEWLINE) begin
          out_valid           <= 1'b1;
          word_length         <= '0;
          integer_accumulator <= '0;
          overflow_seen       <= 1'b0;
          after_point         <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ch == smcp_pkg::CHAR_NEWLINE) begin
      out_code     <= match_code;
      out_value    <= integer_accumulator;
      out_overflow <= overflow_seen;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_BITS'({out_overflow, out_value, out_code});

endmodule
